@@ src/substring_first_match_top_assert.svh @@
// Assertion macros used by the substring search top level.
`ifndef SUBSTRING_FIRST_MATCH_TOP_ASSERT_SVH
`define SUBSTRING_FIRST_MATCH_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked at every rising clock edge outside reset.
`define SFM_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define SFM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define SFM_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define SFM_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

@@ src/sfm_pkg.sv @@
// Package with types, constants and helpers of the substring search block.
`default_nettype none

package sfm_pkg;

   localparam int NEEDLE_BYTES = 16;
   localparam int BYTE_W       = 8;
   localparam int POS_W        = 31;
   localparam int LEN_W        = 5;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 64;
   localparam int NEEDLE_W     = NEEDLE_BYTES * BYTE_W;

   localparam logic [POS_W-1:0]  POS_MAX       = {POS_W{1'b1}};
   localparam logic [BYTE_W-1:0] FOLD_DISTANCE = 8'd32;
   localparam logic [BYTE_W-1:0] CHAR_UPPER_A  = 8'h41;
   localparam logic [BYTE_W-1:0] CHAR_UPPER_Z  = 8'h5A;
   localparam logic [BYTE_W-1:0] CHAR_NUL      = 8'h00;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NEEDLE_LOW   = 3'd0,
      CSR_NEEDLE_HIGH  = 3'd1,
      CSR_NEEDLE_LEN   = 3'd2,
      CSR_CASE_FOLD    = 3'd3,
      CSR_REPORT_END   = 3'd4,
      CSR_START_OFFSET = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [NEEDLE_W-1:0] needle;       // byte 0 in bits 7:0
      logic [LEN_W-1:0]    needle_length;
      logic                case_fold;
      logic                report_end;
      logic [POS_W-1:0]    start_offset;
   } cfg_type;

   // Folds A-Z to lower case when enabled.
   function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] b,
                                                   input logic en);
      logic [BYTE_W-1:0] r;
      r = b;
      if (en && (b >= CHAR_UPPER_A) && (b <= CHAR_UPPER_Z)) begin
         r = b + FOLD_DISTANCE;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ src/sfm_req_if.sv @@
// Input channel interface carrying one haystack byte per word.
`default_nettype none

interface sfm_req_if;
   logic                      valid;
   logic                      ready;
   logic [sfm_pkg::BYTE_W-1:0] hay_byte;
   logic                      hay_last;

   modport source (output valid, output hay_byte, output hay_last, input ready);
   modport sink   (input valid, input hay_byte, input hay_last, output ready);
endinterface

`default_nettype wire

@@ src/sfm_rsp_if.sv @@
// Result channel interface carrying found flag and match index.
`default_nettype none

interface sfm_rsp_if;
   logic                      valid;
   logic                      ready;
   logic                      found;
   logic [sfm_pkg::POS_W-1:0] match_index;

   modport source (output valid, output found, output match_index, input ready);
   modport sink   (input valid, input found, input match_index, output ready);
endinterface

`default_nettype wire

@@ src/sfm_match.sv @@
// Parallel compare of the needle against the byte window.
`default_nettype none

module sfm_match #(
   parameter int MAX_NEEDLE = 16
) (
   input  wire logic [sfm_pkg::BYTE_W-1:0] window [MAX_NEEDLE],
   input  wire sfm_pkg::cfg_type           cfg,
   output logic                            match
);

   localparam int AGE_W = (MAX_NEEDLE > 1) ? $clog2(MAX_NEEDLE) : 1;

   logic [MAX_NEEDLE-1:0] pos_ok;
   logic                  len_ok;

   // Needle byte i lines up with the window byte that is len-1-i bytes old.
   always_comb begin
      for (int i = 0; i < MAX_NEEDLE; i++) begin
         logic [sfm_pkg::LEN_W-1:0]  age;
         logic [sfm_pkg::BYTE_W-1:0] nb;
         logic [sfm_pkg::BYTE_W-1:0] wb;
         age = cfg.needle_length - sfm_pkg::LEN_W'(1) - sfm_pkg::LEN_W'(i);
         nb  = cfg.needle[i*sfm_pkg::BYTE_W +: sfm_pkg::BYTE_W];
         wb  = window[age[AGE_W-1:0]];
         if (sfm_pkg::LEN_W'(i) >= cfg.needle_length) begin
            pos_ok[i] = 1'b1;
         end else begin
            pos_ok[i] = (sfm_pkg::fold_byte(nb, cfg.case_fold) ==
                         sfm_pkg::fold_byte(wb, cfg.case_fold));
         end
      end
   end

   // An empty needle, an overlong one, or a zero first byte never matches.
   assign len_ok = (cfg.needle_length != '0) &&
                   (cfg.needle_length <= sfm_pkg::LEN_W'(MAX_NEEDLE)) &&
                   (cfg.needle[sfm_pkg::BYTE_W-1:0] != sfm_pkg::CHAR_NUL);

   assign match = len_ok && (&pos_ok);

endmodule

`default_nettype wire

@@ src/substring_first_match_top.sv @@
// Top level of the streaming first-match substring search block.
//
//   channel   direction  word contents               accepted when
//   req_ch    in         hay_byte, hay_last          req_ch.valid && req_ch.ready
//   rsp_ch    out        found, match_index          rsp_ch.valid && rsp_ch.ready
//   csr_*     in         csr_index, csr_wr_data      csr_wr_en
//
// One haystack word is taken per cycle unless one is held back; the needle
// compare, the start check and the hit latch all settle in the cycle that
// the word is accepted. The output register loads a result word as the word
// marked last is accepted, and holds it until the sink takes it.
// While a result waits, further non-last words are still accepted; only a
// last word is held back until the output register is free or being emptied.
// Reset is synchronous, active high; it clears all but the window and result data.
`default_nettype none

`include "substring_first_match_top_assert.svh"

module substring_first_match_top #(
   parameter int MAX_NEEDLE = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   sfm_req_if.sink                                req_ch,
   sfm_rsp_if.source                              rsp_ch,
   input  wire logic                              csr_wr_en,
   input  wire logic [sfm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [sfm_pkg::CSR_DATA_W-1:0]    csr_wr_data
);

   localparam int SEEN_W = $clog2(MAX_NEEDLE + 1);
   localparam int POS_W  = sfm_pkg::POS_W;
   localparam int BYTE_W = sfm_pkg::BYTE_W;

   // Configuration registers.
   sfm_pkg::cfg_type cfg_ff;

   // Per-haystack state. The window needs no reset: bytes older than the
   // seen count are never compared.
   logic [BYTE_W-1:0] window_ff [MAX_NEEDLE];
   logic [BYTE_W-1:0] window_in [MAX_NEEDLE];
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [SEEN_W-1:0] seen_ff, seen_in;
   logic              hit_ff, hit_in;
   logic [POS_W-1:0]  hit_idx_ff, hit_idx_in;

   // Output register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic              found_ff, found_in;
   logic [POS_W-1:0]  idx_ff, idx_in;

   logic              req_accept;
   logic              match;
   logic              seen_ok;
   logic              start_ok;
   logic              hit_now;
   logic [POS_W-1:0]  start_pos;
   logic [POS_W-1:0]  end_pos;

   // A last word needs the output register; other words never do.
   assign req_ch.ready = !req_ch.hay_last || !rsp_valid_ff || rsp_ch.ready;
   assign req_accept   = req_ch.valid && req_ch.ready;

   // The window as it stands once the incoming byte is shifted in.
   always_comb begin
      window_in[0] = req_ch.hay_byte;
      for (int k = 1; k < MAX_NEEDLE; k++) begin
         window_in[k] = window_ff[k-1];
      end
   end

   sfm_match #(
      .MAX_NEEDLE (MAX_NEEDLE)
   ) u_match (
      .window (window_in),
      .cfg    (cfg_ff),
      .match  (match)
   );

   always_comb begin
      seen_in = (seen_ff < SEEN_W'(MAX_NEEDLE)) ? seen_ff + SEEN_W'(1) : seen_ff;
      pos_in  = (pos_ff != sfm_pkg::POS_MAX) ? pos_ff + POS_W'(1) : pos_ff;
   end

   // The seen count guarantees pos+1 is at least the needle length here.
   assign end_pos   = pos_ff + POS_W'(1);
   assign start_pos = end_pos - POS_W'(cfg_ff.needle_length);
   assign seen_ok   = (sfm_pkg::LEN_W'(seen_in) >= cfg_ff.needle_length);
   assign start_ok  = (start_pos >= cfg_ff.start_offset);

   // A byte arriving at the saturated position ends no match.
   assign hit_now = !hit_ff && (pos_ff != sfm_pkg::POS_MAX) && match &&
                    seen_ok && start_ok;

   always_comb begin
      hit_in     = hit_ff || hit_now;
      hit_idx_in = hit_idx_ff;
      if (hit_now) begin
         hit_idx_in = cfg_ff.report_end ? end_pos : start_pos;
      end
   end

   // Result register loads on a last word and drains when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      found_in     = found_ff;
      idx_in       = idx_ff;
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_accept && req_ch.hay_last) begin
         rsp_valid_in = 1'b1;
         found_in     = hit_in;
         idx_in       = hit_in ? hit_idx_in : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_wr_en) begin
         case (sfm_pkg::csr_index_type'(csr_index))
            sfm_pkg::CSR_NEEDLE_LOW: begin
               cfg_ff.needle[sfm_pkg::CSR_DATA_W-1:0] <= csr_wr_data;
            end
            sfm_pkg::CSR_NEEDLE_HIGH: begin
               cfg_ff.needle[sfm_pkg::NEEDLE_W-1:sfm_pkg::CSR_DATA_W] <= csr_wr_data;
            end
            sfm_pkg::CSR_NEEDLE_LEN: begin
               cfg_ff.needle_length <= csr_wr_data[sfm_pkg::LEN_W-1:0];
            end
            sfm_pkg::CSR_CASE_FOLD: begin
               cfg_ff.case_fold <= csr_wr_data[0];
            end
            sfm_pkg::CSR_REPORT_END: begin
               cfg_ff.report_end <= csr_wr_data[0];
            end
            sfm_pkg::CSR_START_OFFSET: begin
               cfg_ff.start_offset <= csr_wr_data[POS_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         seen_ff    <= '0;
         hit_ff     <= 1'b0;
         hit_idx_ff <= '0;
      end else if (req_accept) begin
         if (req_ch.hay_last) begin
            pos_ff     <= '0;
            seen_ff    <= '0;
            hit_ff     <= 1'b0;
            hit_idx_ff <= '0;
         end else begin
            pos_ff     <= pos_in;
            seen_ff    <= seen_in;
            hit_ff     <= hit_in;
            hit_idx_ff <= hit_idx_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         for (int k = 0; k < MAX_NEEDLE; k++) begin
            window_ff[k] <= window_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      found_ff <= found_in;
      idx_ff   <= idx_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.found       = found_ff;
   assign rsp_ch.match_index = idx_ff;

   // A last word never overwrites a result that is still waiting.
   `SFM_ASSERT_IMPLY(a_no_overwrite, clock, reset, req_accept && req_ch.hay_last,
                     !rsp_valid_ff || rsp_ch.ready)
   // A result without a match reports index zero.
   `SFM_ASSERT_IMPLY(a_miss_index_zero, clock, reset, rsp_valid_ff && !found_ff,
                     idx_ff == '0)
   // The end of a haystack clears the per-haystack state.
   `SFM_ASSERT_NEXT(a_clear_on_last, clock, reset, req_accept && req_ch.hay_last,
                    pos_ff == '0 && !hit_ff && seen_ff == '0)
   // A latched hit and its index hold until the haystack ends.
   `SFM_ASSERT_NEXT(a_hit_sticky, clock, reset, hit_ff && !(req_accept && req_ch.hay_last),
                    hit_ff && $stable(hit_idx_ff))

endmodule

`default_nettype wire

@@ tb/substring_first_match_top_test.sv @@
// Self-checking testbench for the streaming first-match substring search block.
module substring_first_match_top_test;
   import sfm_pkg::*;

   // Generous cycle budget: roughly ten times the slowest legal run.
   localparam int CYCLE_LIMIT = 400000;
   // Number of haystack words that the random part aims for.
   localparam int WORD_BUDGET = 1600;
   // Length of the one long result-side stall that backs up the block.
   localparam int LONG_STALL = 400;
   // Cycles to let pass once nothing is outstanding; the result register
   // loads in the cycle after the last word is taken.
   localparam int SETTLE_CYCLES = 4;

   // One word on the request channel.
   typedef struct packed {
      logic [BYTE_W-1:0] hay_byte;
      logic              hay_last;
   } hay_word_t;

   // One word on the result channel.
   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] match_index;
   } search_result_t;

   logic clock;
   logic reset = 1'b1;
   logic                  csr_wr_en   = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index   = '0;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;

   sfm_req_if req_ch ();
   sfm_rsp_if rsp_ch ();

   substring_first_match_top #(
      .MAX_NEEDLE (NEEDLE_BYTES)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // Words waiting to be offered, and the results that the accepted words
   // are due to produce, oldest first.
   hay_word_t      hay_words [$];
   search_result_t due_results [$];

   // Bookkeeping shared between the stimulus, the driver and the monitor.
   int unsigned words_queued   = 0;
   int unsigned words_accepted = 0;
   int unsigned error_count    = 0;
   int unsigned cycle_count    = 0;
   int unsigned stall_requests = 0;
   logic        send_bursts    = 1'b1;
   logic        recv_bursts    = 1'b1;

   // Shadow of the configuration registers as the block should hold them.
   cfg_type cfg = '0;

   // Shadow of the per-haystack search state. Element 0 of the window is
   // the newest byte.
   logic [BYTE_W-1:0] window [NEEDLE_BYTES];
   logic [POS_W-1:0]  pos    = '0;
   logic [LEN_W-1:0]  seen   = '0;
   logic              hit    = 1'b0;
   logic [POS_W-1:0]  hit_at = '0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // The comparison key of a byte: with folding enabled, upper-case
   // letters compare as their lower-case forms.
   function automatic logic [BYTE_W-1:0] case_key(input logic [BYTE_W-1:0] b,
                                                  input logic fold);
      if (fold && b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
         return b + FOLD_DISTANCE;
      end
      return b;
   endfunction

   // Swaps the case of a letter and leaves any other byte alone.
   function automatic logic [BYTE_W-1:0] flip_case(input logic [BYTE_W-1:0] b);
      if ((b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) ||
          (b >= CHAR_UPPER_A + FOLD_DISTANCE && b <= CHAR_UPPER_Z + FOLD_DISTANCE)) begin
         return b ^ FOLD_DISTANCE;
      end
      return b;
   endfunction

   // Advances the shadow search by one accepted byte. The window shifts,
   // the needle is compared against the newest bytes, and a hit is latched
   // only if none is held yet. On the last byte the result becomes due and
   // the per-haystack state clears.
   function automatic void scan_byte(input hay_word_t w);
      logic [POS_W:0]   start_at;
      logic [LEN_W-1:0] len;
      logic             match;
      len = cfg.needle_length;
      for (int k = NEEDLE_BYTES - 1; k > 0; k--) begin
         window[k] = window[k-1];
      end
      window[0] = w.hay_byte;
      if (seen < LEN_W'(NEEDLE_BYTES)) begin
         seen++;
      end
      // An empty or overlong needle, or one that begins with a NUL byte,
      // never matches; neither does a window ending at the saturated index.
      if (!hit && pos != POS_MAX && len != '0 && len <= LEN_W'(NEEDLE_BYTES) &&
          cfg.needle[BYTE_W-1:0] != CHAR_NUL && seen >= len) begin
         start_at = {1'b0, pos} + 1'b1 - len;
         if (start_at >= {1'b0, cfg.start_offset}) begin
            match = 1'b1;
            for (int i = 0; i < int'(len); i++) begin
               if (case_key(cfg.needle[i*BYTE_W +: BYTE_W], cfg.case_fold) !=
                   case_key(window[int'(len) - 1 - i], cfg.case_fold)) begin
                  match = 1'b0;
               end
            end
            if (match) begin
               hit    = 1'b1;
               hit_at = cfg.report_end ? pos + 1'b1 : start_at[POS_W-1:0];
            end
         end
      end
      if (pos != POS_MAX) begin
         pos++;
      end
      if (w.hay_last) begin
         due_results.push_back('{found: hit, match_index: hit ? hit_at : '0});
         foreach (window[k]) begin
            window[k] = '0;
         end
         pos    = '0;
         seen   = '0;
         hit    = 1'b0;
         hit_at = '0;
      end
   endfunction

   // Request driver. A word stays on the channel until the block takes it;
   // after a word is taken the driver may pause for a random burst.
   always @(posedge clock) begin : driver
      hay_word_t offered;
      logic      take_next;
      int        send_gap;
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            scan_byte(offered);
            words_accepted++;
         end
         take_next = !req_ch.valid || req_ch.ready;
         if (take_next) begin
            if (send_gap > 0) begin
               send_gap--;
               req_ch.valid <= 1'b0;
            end else if (hay_words.size() > 0) begin
               offered = hay_words.pop_front();
               req_ch.valid    <= 1'b1;
               req_ch.hay_byte <= offered.hay_byte;
               req_ch.hay_last <= offered.hay_last;
               if (send_bursts && $urandom_range(0, 9) == 0) begin
                  send_gap = $urandom_range(1, 14);
               end
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor. Every result word taken is checked against the oldest
   // due result. Ready drops in random bursts, and once for a long stretch
   // whenever the stimulus asks for it.
   always @(posedge clock) begin : monitor
      search_result_t want;
      logic           next_ready;
      int             hold;
      int unsigned    stall_served;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         hold = 0;
         stall_served = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (due_results.size() == 0) begin
               $display("%0t: result with none due: found=%0b match_index=%0d",
                        $time, rsp_ch.found, rsp_ch.match_index);
               error_count++;
            end else begin
               want = due_results.pop_front();
               if (rsp_ch.found !== want.found) begin
                  $display("%0t: found mismatch: expected %0b, actual %0b",
                           $time, want.found, rsp_ch.found);
                  error_count++;
               end
               if (rsp_ch.match_index !== want.match_index) begin
                  $display("%0t: match_index mismatch: expected %0d, actual %0d",
                           $time, want.match_index, rsp_ch.match_index);
                  error_count++;
               end
            end
         end
         if (stall_served != stall_requests) begin
            stall_served = stall_requests;
            hold = LONG_STALL;
         end
         if (hold > 0) begin
            hold--;
            next_ready = 1'b0;
         end else if (recv_bursts && $urandom_range(0, 7) == 0) begin
            hold = $urandom_range(0, 13);
            next_ready = 1'b0;
         end else begin
            next_ready = 1'b1;
         end
         rsp_ch.ready <= next_ready;
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TEST FAILED");
      $finish;
   end

   task automatic push_word(input logic [BYTE_W-1:0] b, input logic last);
      hay_words.push_back('{hay_byte: b, hay_last: last});
      words_queued++;
   endtask

   // Waits until every queued word has been taken and every due result has
   // arrived, then lets the block settle.
   task automatic wait_idle();
      while (words_accepted != words_queued || due_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes one register and updates the shadow the way the block keeps it:
   // narrow registers take only their low bits.
   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      case (idx)
         CSR_NEEDLE_LOW:   cfg.needle[63:0]   = data;
         CSR_NEEDLE_HIGH:  cfg.needle[127:64] = data;
         CSR_NEEDLE_LEN:   cfg.needle_length  = data[LEN_W-1:0];
         CSR_CASE_FOLD:    cfg.case_fold      = data[0];
         CSR_REPORT_END:   cfg.report_end     = data[0];
         CSR_START_OFFSET: cfg.start_offset   = data[POS_W-1:0];
         default: ;
      endcase
   endtask

   // Loads a full configuration once the block is idle. Half the time the
   // unused upper bits of the narrow registers carry random junk.
   task automatic load_config(input logic [NEEDLE_W-1:0] needle, input logic [LEN_W-1:0] len,
                              input logic fold, input logic rep,
                              input logic [POS_W-1:0] offset);
      logic [CSR_DATA_W-1:0] junk;
      wait_idle();
      junk = $urandom_range(0, 1) ? {$urandom(), $urandom()} : '0;
      write_reg(CSR_NEEDLE_LOW, needle[63:0]);
      write_reg(CSR_NEEDLE_HIGH, needle[127:64]);
      write_reg(CSR_NEEDLE_LEN, {junk[CSR_DATA_W-1:LEN_W], len});
      write_reg(CSR_CASE_FOLD, {junk[CSR_DATA_W-1:1], fold});
      write_reg(CSR_REPORT_END, {junk[CSR_DATA_W-1:1], rep});
      write_reg(CSR_START_OFFSET, {junk[CSR_DATA_W-1:POS_W], offset});
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // A needle byte: mostly letters of either case, so that folding matters,
   // plus printable and arbitrary nonzero bytes.
   function automatic logic [BYTE_W-1:0] pick_needle_byte();
      case ($urandom_range(0, 3))
         0:       return CHAR_UPPER_A + BYTE_W'($urandom_range(0, 25));
         1:       return CHAR_UPPER_A + FOLD_DISTANCE + BYTE_W'($urandom_range(0, 25));
         2:       return BYTE_W'($urandom_range(8'h20, 8'h7E));
         default: return BYTE_W'($urandom_range(1, 255));
      endcase
   endfunction

   // Filler for a haystack. Much of it is drawn from the needle itself so
   // that partial and overlapping matches are common.
   function automatic logic [BYTE_W-1:0] pick_noise_byte(input int nl);
      logic [BYTE_W-1:0] b;
      case ($urandom_range(0, 4))
         0: b = BYTE_W'($urandom_range(0, 255));
         1, 2: begin
            b = cfg.needle[$urandom_range(0, nl - 1)*BYTE_W +: BYTE_W];
            if ($urandom_range(0, 1)) begin
               b = flip_case(b);
            end
         end
         3: b = pick_needle_byte();
         default: b = cfg.needle[BYTE_W-1:0];
      endcase
      return b;
   endfunction

   // Queues one haystack: random filler with up to two copies of the needle
   // planted in it, some bytes with swapped case and some spoiled.
   task automatic queue_haystack(input logic short_only);
      logic [BYTE_W-1:0] text [64];
      logic [BYTE_W-1:0] b;
      int n;
      int nl;
      int at;
      int copies;
      nl = (cfg.needle_length == '0) ? 1 :
           (cfg.needle_length > LEN_W'(NEEDLE_BYTES)) ? NEEDLE_BYTES : int'(cfg.needle_length);
      if (short_only) begin
         n = $urandom_range(1, 6);
      end else if ($urandom_range(0, 9) == 0) begin
         n = $urandom_range(25, 60);
      end else begin
         n = $urandom_range(1, 24);
      end
      if (!short_only && n < nl && $urandom_range(0, 3) != 0) begin
         n = nl + $urandom_range(0, 4);
      end
      for (int i = 0; i < n; i++) begin
         text[i] = pick_noise_byte(nl);
      end
      copies = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 2);
      if (n >= nl) begin
         repeat (copies) begin
            at = $urandom_range(0, n - nl);
            for (int j = 0; j < nl; j++) begin
               b = cfg.needle[j*BYTE_W +: BYTE_W];
               if ($urandom_range(0, 1)) begin
                  b = flip_case(b);
               end
               if ($urandom_range(0, 15) == 0) begin
                  b = BYTE_W'($urandom_range(0, 255));
               end
               text[at + j] = b;
            end
         end
      end
      for (int i = 0; i < n; i++) begin
         push_word(text[i], i == n - 1);
      end
   endtask

   initial begin
      logic [NEEDLE_W-1:0] needle;
      logic [LEN_W-1:0]    len;
      logic [POS_W-1:0]    offset;
      logic                final_stretch;
      int                  phase;
      int unsigned         phase_end;

      req_ch.valid    = 1'b0;
      req_ch.hay_byte = '0;
      req_ch.hay_last = 1'b0;
      rsp_ch.ready    = 1'b0;
      foreach (window[k]) begin
         window[k] = '0;
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part. A plain two-byte needle found at index 1 with the
      // case taken literally; the later copy with other case must not count.
      load_config({{64{1'b0}}, 48'h0, "b", "A"}, 5'd2, 1'b0, 1'b0, '0);
      push_word("z", 1'b0);
      push_word("A", 1'b0);
      push_word("b", 1'b0);
      push_word("a", 1'b0);
      push_word("B", 1'b1);
      push_word(8'hFF, 1'b1);

      // Folded compare, end reporting, and a start offset that rules out
      // the earlier copy; the later one reports the index just past it.
      load_config({{64{1'b1}}, 48'h0, "b", "A"}, 5'd2, 1'b1, 1'b1, 31'd2);
      push_word("a", 1'b0);
      push_word("B", 1'b0);
      push_word("a", 1'b0);
      push_word("B", 1'b1);

      // An empty needle never matches.
      load_config({{64{1'b0}}, 48'h0, "b", "A"}, 5'd0, 1'b0, 1'b0, '0);
      push_word("A", 1'b0);
      push_word("b", 1'b1);

      // A length beyond the needle store never matches.
      load_config({{64{1'b0}}, 48'h0, "b", "A"}, 5'd31, 1'b0, 1'b0, '0);
      push_word("A", 1'b0);
      push_word("b", 1'b1);

      // A needle that begins with NUL never matches, even on NUL input.
      load_config({{64{1'b0}}, 48'h0, "A", CHAR_NUL}, 5'd2, 1'b0, 1'b0, '0);
      push_word(CHAR_NUL, 1'b0);
      push_word("A", 1'b1);

      // The largest start offset admits no match at all.
      load_config({{64{1'b0}}, 48'h0, "b", "A"}, 5'd2, 1'b0, 1'b1, POS_MAX);
      push_word("A", 1'b0);
      push_word("b", 1'b1);

      // Random part: each phase draws a configuration and then streams
      // haystacks built around the needle. Phase 2 uses short haystacks
      // and a long result stall so that results back up and the block
      // stalls its input on a last word.
      phase = 0;
      while (words_queued < WORD_BUDGET) begin
         for (int k = 0; k < NEEDLE_BYTES; k++) begin
            needle[k*BYTE_W +: BYTE_W] = pick_needle_byte();
         end
         if ($urandom_range(0, 14) == 0) begin
            needle = '1;
         end
         if ($urandom_range(0, 11) == 0) begin
            needle[BYTE_W-1:0] = CHAR_NUL;
         end
         case ($urandom_range(0, 19))
            0:             len = '0;
            1:             len = LEN_W'($urandom_range(NEEDLE_BYTES + 1, 31));
            2, 3:          len = LEN_W'(NEEDLE_BYTES);
            4, 5, 6, 7, 8, 9, 10, 11: len = LEN_W'($urandom_range(1, 4));
            default:       len = LEN_W'($urandom_range(5, NEEDLE_BYTES - 1));
         endcase
         case ($urandom_range(0, 19))
            0:                      offset = POS_MAX;
            1:                      offset = POS_W'($urandom());
            2, 3, 4, 5, 6, 7, 8:    offset = POS_W'($urandom_range(1, 24));
            default:                offset = '0;
         endcase
         load_config(needle, len, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), offset);

         // The closing stretch of the run has no idling on either side.
         final_stretch = words_queued + 250 > WORD_BUDGET;
         send_bursts = !final_stretch && $urandom_range(0, 3) != 0;
         recv_bursts = !final_stretch && $urandom_range(0, 3) != 0;
         if (phase == 2) begin
            stall_requests++;
         end
         phase_end = words_queued + $urandom_range(50, 110);
         while (words_queued < phase_end) begin
            queue_haystack(phase == 2);
         end
         phase++;
      end

      wait_idle();
      if (error_count == 0 && due_results.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
